// ----- rtl/mtk_pkg.sv -----
// Shared constants, key codes, register indexes and the glyph table
// for the multi-tap text entry block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtk_pkg;

  localparam int MSG_LEN = 16;
  localparam int ADDR_W  = $clog2(MSG_LEN);
  localparam int CUR_W   = $clog2(MSG_LEN + 1);
  localparam int KEY_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int NUM_DIGITS = 10;

  localparam logic [KEY_W-1:0] KEY_CONFIRM = 5'd10;
  localparam logic [KEY_W-1:0] KEY_DELETE  = 5'd11;
  localparam logic [KEY_W-1:0] KEY_SHIFT   = 5'd12;
  localparam logic [KEY_W-1:0] KEY_LEFT    = 5'd13;
  localparam logic [KEY_W-1:0] KEY_RIGHT   = 5'd14;
  localparam logic [KEY_W-1:0] KEY_ENTER   = 5'd15;
  localparam logic [KEY_W-1:0] KEY_NONE    = 5'd16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 2'd1;

  localparam logic [7:0] TIMEOUT_RESET  = 8'd20;
  localparam logic [2:0] PRESCALE_RESET = 3'd3;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef logic [NUM_DIGITS-1:0][3:0] tap_arr_t;

  // one row per digit key, 16 glyphs each, first glyph in the top byte
  localparam logic [127:0] GLYPH_ROWS [NUM_DIGITS] = '{
    "  ?!#$%&*()     ",
    " 0123456789     ",
    " aAbBcC         ",
    " dDeEfF         ",
    " gGhHiI         ",
    " jJkKlL         ",
    " mMnNoO         ",
    " pPqQrRsS       ",
    " tTuUvV         ",
    " wWxXyYzZ       "
  };

  function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] key, input logic [3:0] tap);
    logic [127:0] row;
    row = GLYPH_ROWS[key];
    return row[{~tap, 3'b000} +: CHAR_W];
  endfunction

  // result of one processed tick, handed from the tick logic to the top
  typedef struct packed {
    logic              wrote;
    logic [CUR_W-1:0]  wpos;
    logic [CHAR_W-1:0] wval;
    logic [CUR_W-1:0]  cursor;
    logic              entered;
  } tick_res_t;

endpackage

`default_nettype wire

// ----- rtl/mtk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mtk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mtk_tick.sv -----
// Per-tick state and key action logic: tap counters, cursor, case and
// timeout handling, configuration registers. Uses mtk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtk_tick (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [mtk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            fire,
  input  wire logic [mtk_pkg::KEY_W-1:0]       key,
  output mtk_pkg::tick_res_t                   res
);
  import mtk_pkg::*;

  logic [7:0]       timeout_ticks;
  logic [2:0]       action_prescale;
  tap_arr_t         tap_counts, tap_counts_next;
  logic [CUR_W-1:0] cursor, cursor_next;
  logic [3:0]       current_key, current_key_next;
  logic             current_valid, current_valid_next;
  logic [KEY_W-1:0] pending_key, pending_key_next;
  logic             writing, writing_next;
  logic             shift_pending, shift_pending_next;
  logic             upper_case, upper_case_next;
  logic [7:0]       idle_count, idle_count_next;
  logic [2:0]       prescale_count, prescale_count_next;

  logic             wrote, entered, fresh;
  logic [CUR_W-1:0] wpos;
  logic [CHAR_W-1:0] wval;
  logic [KEY_W-1:0] k;
  logic [3:0]       kd, tap, top_up, top_lo;

  // drop the pending letter's tap counter
  function automatic tap_arr_t clear_tap(input tap_arr_t tc, input logic cv,
                                         input logic [3:0] ck);
    tap_arr_t r;
    r = tc;
    if (cv && ck < 4'(NUM_DIGITS)) begin
      r[ck] = 4'd0;
    end
    return r;
  endfunction

  always_comb begin
    tap_counts_next     = tap_counts;
    cursor_next         = cursor;
    current_key_next    = current_key;
    current_valid_next  = current_valid;
    pending_key_next    = pending_key;
    writing_next        = writing;
    shift_pending_next  = shift_pending;
    upper_case_next     = upper_case;
    idle_count_next     = idle_count;
    wrote   = 1'b0;
    entered = 1'b0;
    fresh   = 1'b0;
    wpos    = '0;
    wval    = '0;
    kd      = 4'd0;
    tap     = 4'd0;
    top_up  = 4'd6;
    top_lo  = 4'd5;

    if (key < KEY_NONE) begin
      pending_key_next = key;
    end
    prescale_count_next = prescale_count + 3'd1;

    // idle timeout
    if (writing) begin
      if (idle_count < timeout_ticks) begin
        idle_count_next = idle_count + 8'd1;
      end else begin
        tap_counts_next    = clear_tap(tap_counts_next, current_valid_next, current_key_next);
        idle_count_next    = 8'd0;
        writing_next       = 1'b0;
        current_valid_next = 1'b0;
        current_key_next   = 4'd0;
        pending_key_next   = KEY_NONE;
        if (cursor_next < CUR_W'(MSG_LEN)) begin
          cursor_next = cursor_next + CUR_W'(1);
        end
      end
    end

    k = pending_key_next;
    if (prescale_count_next == action_prescale) begin
      prescale_count_next = 3'd0;
      if (cursor_next < CUR_W'(MSG_LEN)) begin
        if (k < KEY_W'(NUM_DIGITS)) begin
          kd = k[3:0];
          fresh = !writing_next || !current_valid_next || current_key_next != kd;
          if (fresh) begin
            if (writing_next) begin
              tap_counts_next = clear_tap(tap_counts_next, current_valid_next,
                                          current_key_next);
            end
            writing_next       = 1'b1;
            current_key_next   = kd;
            current_valid_next = 1'b1;
          end
          tap = tap_counts_next[kd];
          if (kd >= 4'd2) begin
            if (shift_pending_next) begin
              if (!upper_case_next) begin
                tap = tap + 4'd1;
                upper_case_next = 1'b1;
              end else begin
                tap = tap - 4'd1;
                upper_case_next = 1'b0;
              end
              shift_pending_next = 1'b0;
            end
            top_up = (kd == 4'd7 || kd == 4'd9) ? 4'd8 : 4'd6;
            top_lo = top_up - 4'd1;
            if (upper_case_next) begin
              tap = (tap >= top_up) ? 4'd2 : tap + 4'd2;
            end else begin
              tap = (tap >= top_lo) ? 4'd1 : tap + 4'd2;
            end
            if (fresh) begin
              tap = upper_case_next ? 4'd2 : 4'd1;
            end
          end else begin
            tap = (tap < 4'd10) ? tap + 4'd1 : 4'd1;
          end
          tap_counts_next[kd] = tap;
          wrote = 1'b1;
          wpos  = cursor_next;
          wval  = glyph(kd, tap);
          idle_count_next = 8'd0;
        end else if (k == KEY_CONFIRM) begin
          if (writing_next) begin
            tap_counts_next    = clear_tap(tap_counts_next, current_valid_next,
                                           current_key_next);
            idle_count_next    = 8'd0;
            writing_next       = 1'b0;
            current_valid_next = 1'b0;
            current_key_next   = 4'd0;
            cursor_next        = cursor_next + CUR_W'(1);
          end
        end else if (k == KEY_RIGHT) begin
          // the entry past the last message slot is the terminator
          if (cursor_next < CUR_W'(MSG_LEN - 1)) begin
            cursor_next = cursor_next + CUR_W'(1);
          end
        end else if (k == KEY_SHIFT) begin
          shift_pending_next = !shift_pending_next;
        end
      end
      if (cursor_next != '0) begin
        if (k == KEY_DELETE) begin
          if (writing_next) begin
            tap_counts_next    = clear_tap(tap_counts_next, current_valid_next,
                                           current_key_next);
            idle_count_next    = 8'd0;
            writing_next       = 1'b0;
            current_valid_next = 1'b0;
            current_key_next   = 4'd0;
          end else begin
            cursor_next = cursor_next - CUR_W'(1);
          end
          if (cursor_next < CUR_W'(MSG_LEN)) begin
            wrote = 1'b1;
            wpos  = cursor_next;
            wval  = CHAR_SPACE;
          end
        end else if (k == KEY_LEFT) begin
          cursor_next = cursor_next - CUR_W'(1);
        end
      end
      if (k == KEY_ENTER) begin
        tap_counts_next    = clear_tap(tap_counts_next, current_valid_next, current_key_next);
        idle_count_next    = 8'd0;
        writing_next       = 1'b0;
        current_valid_next = 1'b0;
        current_key_next   = 4'd0;
        entered            = 1'b1;
      end
      pending_key_next = KEY_NONE;
    end
  end

  assign res.wrote   = wrote;
  assign res.wpos    = wpos;
  assign res.wval    = wval;
  assign res.cursor  = cursor_next;
  assign res.entered = entered;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RESET;
      action_prescale <= PRESCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TIMEOUT) begin
        timeout_ticks <= cfg_data;
      end else if (cfg_index == REG_PRESCALE) begin
        action_prescale <= cfg_data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_counts     <= '0;
      cursor         <= '0;
      current_key    <= 4'd0;
      current_valid  <= 1'b0;
      pending_key    <= KEY_NONE;
      writing        <= 1'b0;
      shift_pending  <= 1'b0;
      upper_case     <= 1'b0;
      idle_count     <= 8'd0;
      prescale_count <= 3'd0;
    end else if (fire) begin
      tap_counts     <= tap_counts_next;
      cursor         <= cursor_next;
      current_key    <= current_key_next;
      current_valid  <= current_valid_next;
      pending_key    <= pending_key_next;
      writing        <= writing_next;
      shift_pending  <= shift_pending_next;
      upper_case     <= upper_case_next;
      idle_count     <= idle_count_next;
      prescale_count <= prescale_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multitap_keypad_text_entry.sv -----
// Multi-tap keypad text entry, top level: input register, tick logic,
// message RAM, Enter readout and output register. Uses mtk_pkg, mtk_tick, mtk_ram.
// Status path: the status result of a tick passes the input register, then the output register.
// Throughput: one tick per cycle while the output is not stalled. An Enter tick holds off
// further ticks while its up to MSG_LEN character results follow one per cycle, unless
// stalled, the first delayed by the registered RAM read.
// Reset (rst, synchronous): control state and registers to their defaults;
// RAM contents are kept, per-entry written bits make unwritten slots read as spaces.
`timescale 1ns / 1ps
`default_nettype none

module multitap_keypad_text_entry (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [mtk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                      cfg_data,
  // tick input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mtk_pkg::KEY_W-1:0]       key_code,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 result_kind,
  output logic      [mtk_pkg::CUR_W-1:0]       cursor_pos,
  output logic                                 char_valid,
  output logic      [mtk_pkg::CUR_W-1:0]       char_pos,
  output logic      [mtk_pkg::CHAR_W-1:0]      char_value,
  output logic                                 last
);
  import mtk_pkg::*;

  // input register
  logic             hold_valid;
  logic [KEY_W-1:0] hold_key;

  // Enter readout
  logic              emit_busy;
  logic              issue_done;
  logic [ADDR_W-1:0] issue_idx;
  logic [ADDR_W-1:0] last_idx;
  logic [CUR_W-1:0]  emit_cursor;
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_idx;
  logic              rd_last;
  logic              rd_written;
  logic [CHAR_W-1:0] rd_data;
  logic [MSG_LEN-1:0] written;

  logic      out_free, fire, issue, rd_take;
  tick_res_t res;

  assign out_free = !out_valid || !out_stall;
  // a tick is processed only when no readout is running (it would overwrite RAM)
  assign fire     = hold_valid && !emit_busy && out_free;
  assign in_stall = hold_valid && !fire;
  assign rd_take  = rd_valid && out_free;
  assign issue    = emit_busy && !issue_done && (!rd_valid || rd_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_key <= key_code;
    end
  end

  mtk_tick u_tick (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .key       (hold_key),
    .res       (res)
  );

  mtk_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MSG_LEN)
  ) u_msg_ram (
    .clk     (clk),
    .wr_en   (fire && res.wrote),
    .wr_addr (res.wpos[ADDR_W-1:0]),
    .wr_data (res.wval),
    .rd_en   (issue),
    .rd_addr (issue_idx),
    .rd_data (rd_data)
  );

  // slot written since reset; otherwise it is read out as a space
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (fire && res.wrote) begin
      written[res.wpos[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // readout control: read stage feeds the output register, stalls with it
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy  <= 1'b0;
      issue_done <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (fire && res.entered) begin
        emit_busy  <= 1'b1;
        issue_done <= 1'b0;
      end else if (rd_take && rd_last) begin
        emit_busy <= 1'b0;
      end
      if (issue) begin
        rd_valid <= 1'b1;
        if (issue_idx == last_idx) begin
          issue_done <= 1'b1;
        end
      end else if (rd_take) begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.entered) begin
      issue_idx   <= '0;
      emit_cursor <= res.cursor;
      // characters 0 through the cursor, at most MSG_LEN of them
      last_idx    <= (res.cursor == CUR_W'(MSG_LEN)) ? ADDR_W'(MSG_LEN - 1)
                                                     : res.cursor[ADDR_W-1:0];
    end else if (issue) begin
      issue_idx <= issue_idx + ADDR_W'(1);
    end
    if (issue) begin
      rd_idx     <= issue_idx;
      rd_last    <= (issue_idx == last_idx);
      rd_written <= written[issue_idx];
    end
  end

  // output register: status result on a processed tick, else a readout char
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire || rd_take;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_kind <= 1'b0;
      cursor_pos  <= res.cursor;
      char_valid  <= res.wrote;
      char_pos    <= res.wpos;
      char_value  <= res.wval;
      last        <= !res.entered;
    end else if (rd_take) begin
      result_kind <= 1'b1;
      cursor_pos  <= emit_cursor;
      char_valid  <= 1'b1;
      char_pos    <= CUR_W'(rd_idx);
      char_value  <= rd_written ? rd_data : CHAR_SPACE;
      last        <= rd_last;
    end
  end

endmodule

`default_nettype wire
